// ===== hdl/euq_pkg.sv =====
package euq_pkg;

  // Default angle width; Q(3).(AngleBits-3) radians.
  localparam int ANGLE_BITS_DEF = 16;

  // Q1.30 constants. Angle constants are wider than 32 bits to hold pi and beyond.
  localparam logic signed [31:0] ONE_Q30        = 32'sd1073741824;
  localparam logic signed [33:0] PI_Q30         = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30    = 34'sd1686629713;
  localparam logic signed [33:0] QUARTER_PI_Q30 = 34'sd843314857;
  localparam logic signed [31:0] SAT_MAX        = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN        = -32'sh7fff_ffff - 32'sd1;
  localparam logic signed [18:0] OUT_MAX        = 19'sd16384;

  // Register map of the configuration port.
  localparam int NUM_REGS = 7;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SIN_COEF_0 = 3'd0,
    REG_SIN_COEF_1 = 3'd1,
    REG_SIN_COEF_2 = 3'd2,
    REG_COS_BASE   = 3'd3,
    REG_COS_COEF_0 = 3'd4,
    REG_COS_COEF_1 = 3'd5,
    REG_COS_COEF_2 = 3'd6
  } reg_idx_e;

  localparam logic signed [31:0] RST_SIN_COEF_0 = 32'sd178956971;
  localparam logic signed [31:0] RST_SIN_COEF_1 = 32'sd8947849;
  localparam logic signed [31:0] RST_SIN_COEF_2 = 32'sd213044;
  localparam logic signed [31:0] RST_COS_BASE   = 32'sd1073741824;
  localparam logic signed [31:0] RST_COS_COEF_0 = 32'sd536870912;
  localparam logic signed [31:0] RST_COS_COEF_1 = 32'sd44739243;
  localparam logic signed [31:0] RST_COS_COEF_2 = 32'sd1491308;

  // Pipeline depth: seven stages of sine/cosine, three of quaternion assembly.
  localparam int SC_STAGES   = 7;
  localparam int COMB_STAGES = 3;
  localparam int LATENCY     = SC_STAGES + COMB_STAGES;

  typedef struct packed {
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] b;
    logic signed [31:0] d0;
    logic signed [31:0] d1;
    logic signed [31:0] d2;
  } coef_t;

  // Per-lane control carried down the polynomial pipeline.
  typedef struct packed {
    logic sel;      // sine polynomial when set, cosine polynomial otherwise
    logic n_in;     // negate after the fold by pi
    logic n_out;    // negate after the fold by sign
    logic frc;      // result forced (zero angle)
    logic frc_one;  // forced value is one rather than zero
  } ctl_t;

  typedef struct packed {
    logic signed [31:0] y;
    logic signed [31:0] w;
    logic sel;
    logic n_in;
    logic n_out;
  } fold_t;

  // Q1.30 product, rounded half up.
  function automatic logic signed [33:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + 64'sd536870912;
    return 34'(p >>> 30);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'(SAT_MAX)) return SAT_MAX;
    if (v < 36'(SAT_MIN)) return SAT_MIN;
    return 32'(v);
  endfunction

  function automatic logic signed [31:0] satneg(input logic signed [31:0] v);
    if (v == SAT_MIN) return SAT_MAX;
    return -v;
  endfunction

  // Fold an angle by sign, by pi and by pi/2 onto [0, pi/2].
  function automatic fold_t fold(input logic signed [33:0] x);
    fold_t f;
    logic signed [33:0] a;
    logic signed [33:0] b;
    logic signed [33:0] c;
    f.n_out = x < 0;
    a = f.n_out ? -x : x;
    f.n_in = a > PI_Q30;
    b = f.n_in ? a - PI_Q30 : a;
    c = (b > HALF_PI_Q30) ? PI_Q30 - b : b;
    f.sel = c <= QUARTER_PI_Q30;
    f.y = 32'(c);
    f.w = f.sel ? 32'(c) : 32'(HALF_PI_Q30 - c);
    return f;
  endfunction

endpackage

// ===== hdl/euq_if.sv =====
// Request channel: three Euler angles.
interface euq_req_if #(parameter int AngleBits = euq_pkg::ANGLE_BITS_DEF);
  logic valid;
  logic ready;
  logic signed [AngleBits-1:0] angle_x;
  logic signed [AngleBits-1:0] angle_y;
  logic signed [AngleBits-1:0] angle_z;
  modport source(output valid, angle_x, angle_y, angle_z, input ready);
  modport sink(input valid, angle_x, angle_y, angle_z, output ready);
endinterface

// Result channel: quaternion in Q1.14.
interface euq_res_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// Configuration write channel.
interface euq_cfg_if;
  logic valid;
  logic ready;
  logic [euq_pkg::CFG_IDX_BITS-1:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/euq_sincos.sv =====
module euq_sincos #(
  parameter int AngleBits = euq_pkg::ANGLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [AngleBits-1:0] angle_i,
  input  euq_pkg::coef_t              coef_i,
  output logic signed [31:0]          sin_o,
  output logic signed [31:0]          cos_o
);
  import euq_pkg::*;

  localparam int Shift = 32 - AngleBits;

  // Lane 0 computes the sine, lane 1 the cosine.
  logic signed [31:0] half;
  fold_t              fl [2];
  logic signed [31:0] w1_q [2], y1_q [2];
  logic signed [31:0] z2_q [2], y2_q [2];
  logic signed [31:0] t3_q [2], z3_q [2], y3_q [2];
  logic signed [31:0] t4_q [2], z4_q [2], y4_q [2];
  logic signed [31:0] t5_q [2], y5_q [2];
  logic signed [31:0] r6_q [2];
  logic signed [31:0] r7_q [2];
  ctl_t               c1_q [2], c2_q [2], c3_q [2], c4_q [2], c5_q [2], c6_q [2];

  // Half angle in Q1.30.
  assign half = 32'(angle_i) << Shift;

  always_comb begin
    fl[0] = fold(34'(half));
    fl[1] = fold(34'(half) + HALF_PI_Q30);
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [31:0] k1, k2, k0, ka, v1, v2;

    always_comb begin
      k1 = c2_q[l].sel ? coef_i.c1 : coef_i.d1;
      k2 = c2_q[l].sel ? coef_i.c2 : coef_i.d2;
      k0 = c3_q[l].sel ? coef_i.c0 : coef_i.d0;
      ka = c4_q[l].sel ? ONE_Q30 : coef_i.b;
      v1 = c6_q[l].n_in ? satneg(r6_q[l]) : r6_q[l];
      v2 = c6_q[l].n_out ? satneg(v1) : v1;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // Stage 1: fold.
        w1_q[l]         <= fl[l].w;
        y1_q[l]         <= fl[l].y;
        c1_q[l].sel     <= fl[l].sel;
        c1_q[l].n_in    <= fl[l].n_in;
        c1_q[l].n_out   <= fl[l].n_out;
        c1_q[l].frc     <= (half == '0);
        c1_q[l].frc_one <= (l == 1);
        // Stage 2: square of the folded argument.
        z2_q[l] <= 32'(mulq(w1_q[l], w1_q[l]));
        y2_q[l] <= y1_q[l];
        c2_q[l] <= c1_q[l];
        // Stage 3: innermost Horner step.
        t3_q[l] <= sat32(36'(k1) - 36'(mulq(k2, z2_q[l])));
        z3_q[l] <= z2_q[l];
        y3_q[l] <= y2_q[l];
        c3_q[l] <= c2_q[l];
        // Stage 4.
        t4_q[l] <= sat32(36'(k0) - 36'(mulq(z3_q[l], t3_q[l])));
        z4_q[l] <= z3_q[l];
        y4_q[l] <= y3_q[l];
        c4_q[l] <= c3_q[l];
        // Stage 5: outer Horner step, constant term one or the cosine base.
        t5_q[l] <= sat32(36'(ka) - 36'(mulq(z4_q[l], t4_q[l])));
        y5_q[l] <= y4_q[l];
        c5_q[l] <= c4_q[l];
        // Stage 6: the sine polynomial takes a final factor of y.
        r6_q[l] <= c5_q[l].sel ? sat32(36'(mulq(y5_q[l], t5_q[l]))) : t5_q[l];
        c6_q[l] <= c5_q[l];
        // Stage 7: undo the folds, or force the zero-angle value.
        if (c6_q[l].frc) begin
          r7_q[l] <= c6_q[l].frc_one ? ONE_Q30 : '0;
        end else begin
          r7_q[l] <= v2;
        end
      end
    end
  end

  assign sin_o = r7_q[0];
  assign cos_o = r7_q[1];

endmodule

// ===== hdl/euq_comb.sv =====
module euq_comb (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] sx_i,
  input  logic signed [31:0] cx_i,
  input  logic signed [31:0] sy_i,
  input  logic signed [31:0] cy_i,
  input  logic signed [31:0] sz_i,
  input  logic signed [31:0] cz_i,
  output logic signed [15:0] quat_w_o,
  output logic signed [15:0] quat_x_o,
  output logic signed [15:0] quat_y_o,
  output logic signed [15:0] quat_z_o
);
  import euq_pkg::*;

  logic signed [31:0] ss_q, cc_q, cxsy_q, sxcy_q, cxcy_q, sxsy_q;
  logic signed [31:0] sx_q, cx_q, sz_q, cz_q;
  logic signed [33:0] p_q [8];
  logic signed [15:0] q_q [4];
  logic signed [34:0] sum [4];

  // Round Q1.30 to Q1.14 half up and clamp to plus or minus one.
  function automatic logic signed [15:0] to_out(input logic signed [34:0] v);
    logic signed [34:0] r;
    logic signed [18:0] t;
    r = v + 35'sd32768;
    t = 19'(r >>> 16);
    if (t > OUT_MAX) t = OUT_MAX;
    if (t < -OUT_MAX) t = -OUT_MAX;
    return 16'(t);
  endfunction

  always_comb begin
    sum[0] = 35'(p_q[0]) + 35'(p_q[1]);
    sum[1] = 35'(p_q[2]) - 35'(p_q[3]);
    sum[2] = 35'(p_q[4]) + 35'(p_q[5]);
    sum[3] = 35'(p_q[6]) - 35'(p_q[7]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Pair products.
      ss_q   <= sat32(36'(mulq(sy_i, sz_i)));
      cc_q   <= sat32(36'(mulq(cy_i, cz_i)));
      cxsy_q <= sat32(36'(mulq(cx_i, sy_i)));
      sxcy_q <= sat32(36'(mulq(sx_i, cy_i)));
      cxcy_q <= sat32(36'(mulq(cx_i, cy_i)));
      sxsy_q <= sat32(36'(mulq(sx_i, sy_i)));
      sx_q   <= sx_i;
      cx_q   <= cx_i;
      sz_q   <= sz_i;
      cz_q   <= cz_i;
      // Triple products.
      p_q[0] <= mulq(cx_q, cc_q);
      p_q[1] <= mulq(sx_q, ss_q);
      p_q[2] <= mulq(sx_q, cc_q);
      p_q[3] <= mulq(cx_q, ss_q);
      p_q[4] <= mulq(cz_q, cxsy_q);
      p_q[5] <= mulq(sz_q, sxcy_q);
      p_q[6] <= mulq(sz_q, cxcy_q);
      p_q[7] <= mulq(cz_q, sxsy_q);
      // Sums and output formatting.
      for (int i = 0; i < 4; i++) begin
        q_q[i] <= to_out(sum[i]);
      end
    end
  end

  assign quat_w_o = q_q[0];
  assign quat_x_o = q_q[1];
  assign quat_y_o = q_q[2];
  assign quat_z_o = q_q[3];

endmodule

// ===== hdl/euler_to_quaternion.sv =====
// Euler angles to unit quaternion, fully pipelined.
// Stages from request acceptance to result valid: seven of sine/cosine
// polynomial, three of quaternion products and rounding.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset clears the valid bits and loads the Taylor coefficients; no clearing pass.
module euler_to_quaternion #(
  parameter int ANGLE_BITS = euq_pkg::ANGLE_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  euq_req_if.sink   req_i,
  euq_res_if.source res_o,
  euq_cfg_if.sink   cfg_i
);
  import euq_pkg::*;

  coef_t                 coef_q;
  logic [LATENCY-1:0]    vld_q;
  logic                  en;
  logic signed [31:0]    sx, cx, sy, cy, sz, cz;

  // The pipeline advances unless a finished result is held back.
  assign en          = !vld_q[LATENCY-1] || res_o.ready;
  assign req_i.ready = en;
  assign res_o.valid = vld_q[LATENCY-1];
  assign cfg_i.ready = 1'b1;

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LATENCY-2:0], req_i.valid};
    end
  end

  // Coefficient registers; indices beyond the map are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.c0 <= RST_SIN_COEF_0;
      coef_q.c1 <= RST_SIN_COEF_1;
      coef_q.c2 <= RST_SIN_COEF_2;
      coef_q.b  <= RST_COS_BASE;
      coef_q.d0 <= RST_COS_COEF_0;
      coef_q.d1 <= RST_COS_COEF_1;
      coef_q.d2 <= RST_COS_COEF_2;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_SIN_COEF_0: coef_q.c0 <= cfg_i.data;
        REG_SIN_COEF_1: coef_q.c1 <= cfg_i.data;
        REG_SIN_COEF_2: coef_q.c2 <= cfg_i.data;
        REG_COS_BASE:   coef_q.b  <= cfg_i.data;
        REG_COS_COEF_0: coef_q.d0 <= cfg_i.data;
        REG_COS_COEF_1: coef_q.d1 <= cfg_i.data;
        REG_COS_COEF_2: coef_q.d2 <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // One sine/cosine pipeline per axis.
  euq_sincos #(.AngleBits(ANGLE_BITS)) u_sc_x (
    .clk_i, .en_i(en), .angle_i(req_i.angle_x), .coef_i(coef_q), .sin_o(sx), .cos_o(cx)
  );
  euq_sincos #(.AngleBits(ANGLE_BITS)) u_sc_y (
    .clk_i, .en_i(en), .angle_i(req_i.angle_y), .coef_i(coef_q), .sin_o(sy), .cos_o(cy)
  );
  euq_sincos #(.AngleBits(ANGLE_BITS)) u_sc_z (
    .clk_i, .en_i(en), .angle_i(req_i.angle_z), .coef_i(coef_q), .sin_o(sz), .cos_o(cz)
  );

  // Quaternion assembly.
  euq_comb u_comb (
    .clk_i,
    .en_i(en),
    .sx_i(sx), .cx_i(cx), .sy_i(sy), .cy_i(cy), .sz_i(sz), .cz_i(cz),
    .quat_w_o(res_o.quat_w),
    .quat_x_o(res_o.quat_x),
    .quat_y_o(res_o.quat_y),
    .quat_z_o(res_o.quat_z)
  );

endmodule

// ===== dv/euq_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels, predicts each quaternion from the accepted angles
// and compares every accepted result against the oldest prediction.
module euq_checker (
  input  logic clk_i,
  input  logic rst_ni,
  euq_req_if   req,
  euq_res_if   res,
  euq_cfg_if   cfg,
  output int   fail_count_o,
  output int   pending_o
);
  import euq_pkg::*;

  localparam longint TwoPiQ30 = 64'sd6746518852;

  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  longint coef[NUM_REGS];
  quat_t  quat_q[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Round half up, then floor, by an arithmetic shift.
  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return round_shift(a * b, 30);
  endfunction

  // Polynomial on the folded angle, y in [0, pi/2].
  function automatic longint poly_eval(input longint y);
    longint z;
    longint t;
    if (y <= longint'(QUARTER_PI_Q30)) begin
      z = qmul(y, y);
      t = clamp32(coef[REG_SIN_COEF_1] - qmul(coef[REG_SIN_COEF_2], z));
      t = clamp32(coef[REG_SIN_COEF_0] - qmul(z, t));
      t = clamp32(longint'(ONE_Q30) - qmul(z, t));
      return clamp32(qmul(y, t));
    end
    z = longint'(HALF_PI_Q30) - y;
    z = qmul(z, z);
    t = clamp32(coef[REG_COS_COEF_1] - qmul(coef[REG_COS_COEF_2], z));
    t = clamp32(coef[REG_COS_COEF_0] - qmul(z, t));
    return clamp32(coef[REG_COS_BASE] - qmul(z, t));
  endfunction

  function automatic longint fold_pi(input longint y);
    if (y <= longint'(HALF_PI_Q30)) return poly_eval(y);
    return poly_eval(longint'(PI_Q30) - y);
  endfunction

  function automatic longint fold_turn(input longint y);
    longint r;
    r = y;
    if (r > TwoPiQ30) r = r - ((r - 1) / TwoPiQ30) * TwoPiQ30;
    if (r <= longint'(PI_Q30)) return fold_pi(r);
    return clamp32(-fold_pi(r - longint'(PI_Q30)));
  endfunction

  function automatic longint sine_q30(input longint x);
    if (x == 0) return 0;
    if (x < 0) return clamp32(-fold_turn(-x));
    return fold_turn(x);
  endfunction

  // Cosine is the sine shifted by a quarter turn; zero gives exactly one.
  function automatic longint cosine_q30(input longint x);
    longint y;
    if (x == 0) return longint'(ONE_Q30);
    y = x + longint'(HALF_PI_Q30);
    if (y < 0) return clamp32(-fold_turn(-y));
    return fold_turn(y);
  endfunction

  function automatic logic signed [15:0] to_q14(input longint v);
    longint r;
    r = round_shift(v, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  function automatic quat_t predict_quat(input logic signed [15:0] ax,
                                         input logic signed [15:0] ay,
                                         input logic signed [15:0] az);
    quat_t  q;
    longint hx, hy, hz, cx, cy, cz, sx, sy, sz;
    longint ss, cc, cxsy, sxcy, cxcy, sxsy;
    hx = longint'(ax) * 65536;
    hy = longint'(ay) * 65536;
    hz = longint'(az) * 65536;
    cx = cosine_q30(hx); cy = cosine_q30(hy); cz = cosine_q30(hz);
    sx = sine_q30(hx);   sy = sine_q30(hy);   sz = sine_q30(hz);
    ss   = clamp32(qmul(sy, sz));
    cc   = clamp32(qmul(cy, cz));
    cxsy = clamp32(qmul(cx, sy));
    sxcy = clamp32(qmul(sx, cy));
    cxcy = clamp32(qmul(cx, cy));
    sxsy = clamp32(qmul(sx, sy));
    q.w = to_q14(qmul(cx, cc) + qmul(sx, ss));
    q.x = to_q14(qmul(sx, cc) - qmul(cx, ss));
    q.y = to_q14(qmul(cz, cxsy) + qmul(sz, sxcy));
    q.z = to_q14(qmul(sz, cxcy) - qmul(cz, sxsy));
    return q;
  endfunction

  // Sample at the falling edge: the handshake seen here is the one taken at the
  // next rising edge, since the stimulus only changes on rising edges.
  always @(negedge clk_i or negedge rst_ni) begin
    quat_t q;
    if (!rst_ni) begin
      coef[REG_SIN_COEF_0] = RST_SIN_COEF_0;
      coef[REG_SIN_COEF_1] = RST_SIN_COEF_1;
      coef[REG_SIN_COEF_2] = RST_SIN_COEF_2;
      coef[REG_COS_BASE]   = RST_COS_BASE;
      coef[REG_COS_COEF_0] = RST_COS_COEF_0;
      coef[REG_COS_COEF_1] = RST_COS_COEF_1;
      coef[REG_COS_COEF_2] = RST_COS_COEF_2;
      quat_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg.valid && cfg.ready && cfg.index < NUM_REGS) begin
        coef[cfg.index] = longint'(signed'(cfg.data));
      end
      if (req.valid && req.ready) begin
        quat_q.push_back(predict_quat(req.angle_x, req.angle_y, req.angle_z));
      end
      if (res.valid && res.ready) begin
        if (quat_q.size() == 0) begin
          $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d", $time,
                   res.quat_w, res.quat_x, res.quat_y, res.quat_z);
          fail_count_o++;
        end else begin
          q = quat_q.pop_front();
          if (q.w !== res.quat_w || q.x !== res.quat_x ||
              q.y !== res.quat_y || q.z !== res.quat_z) begin
            $display("%0t: expected w=%0d x=%0d y=%0d z=%0d actual w=%0d x=%0d y=%0d z=%0d",
                     $time, q.w, q.x, q.y, q.z,
                     res.quat_w, res.quat_x, res.quat_y, res.quat_z);
            fail_count_o++;
          end
        end
      end
      pending_o = quat_q.size();
    end
  end

endmodule

// ===== dv/euler_to_quaternion_tb.sv =====
`timescale 1ns / 1ps

module euler_to_quaternion_tb;
  import euq_pkg::*;

  // Index beyond the register map; writes to it must be ignored.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;
  localparam logic signed [15:0] ANG_QUARTER = 16'sd12868;  // pi/2 in Q3.13
  localparam logic signed [15:0] ANG_HALF    = 16'sd25736;  // pi in Q3.13

  logic clk_i;
  logic rst_ni;
  int   tx_idle;
  int   rx_idle;
  int   fail_count;
  int   pending;

  euq_req_if req ();
  euq_res_if res ();
  euq_cfg_if cfg ();

  euler_to_quaternion dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .res_o (res),
    .cfg_i (cfg)
  );

  euq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .res         (res),
    .cfg         (cfg),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    res.ready <= ($urandom_range(99) >= rx_idle);
  end

  // Angles biased towards the fold boundaries, zero and the extremes.
  function automatic logic signed [15:0] pick_angle();
    logic signed [15:0] base;
    case ($urandom_range(6))
      0: return 16'($urandom);
      1: return 16'($urandom_range(1023)) - 16'sd512;
      2: base = ANG_QUARTER;
      3: base = ANG_HALF;
      4: base = 16'sd32767 - 16'($urandom_range(3));
      5: return 16'sd0;
      default: return 16'($urandom);
    endcase
    base = base + 16'($urandom_range(8)) - 16'sd4;
    return $urandom_range(1) ? -base : base;
  endfunction

  task automatic send_angles(input logic signed [15:0] ax,
                             input logic signed [15:0] ay,
                             input logic signed [15:0] az);
    logic took;
    while ($urandom_range(99) < tx_idle) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid   <= 1'b1;
    req.angle_x <= ax;
    req.angle_y <= ay;
    req.angle_z <= az;
    do begin
      @(negedge clk_i);
      took = req.ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
    logic took;
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do begin
      @(negedge clk_i);
      took = cfg.ready;
      @(posedge clk_i);
    end while (!took);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Let the pipeline drain completely before touching the registers.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic load_coefs(input int mode);
    logic [31:0] defaults [NUM_REGS];
    logic [31:0] val;
    defaults[REG_SIN_COEF_0] = RST_SIN_COEF_0;
    defaults[REG_SIN_COEF_1] = RST_SIN_COEF_1;
    defaults[REG_SIN_COEF_2] = RST_SIN_COEF_2;
    defaults[REG_COS_BASE]   = RST_COS_BASE;
    defaults[REG_COS_COEF_0] = RST_COS_COEF_0;
    defaults[REG_COS_COEF_1] = RST_COS_COEF_1;
    defaults[REG_COS_COEF_2] = RST_COS_COEF_2;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (mode)
        0: val = defaults[i];
        1: val = $urandom;
        2: val = 32'h7fff_ffff;
        3: val = 32'h8000_0000;
        4: val = 32'h0;
        default: val = defaults[i] + $urandom_range(2047) - 1024;
      endcase
      write_reg(reg_idx_e'(i), val);
    end
    write_reg(REG_UNMAPPED, $urandom);
  endtask

  initial begin
    int setting [6];
    setting = '{0, 1, 2, 3, 4, 5};
    rst_ni      = 1'b0;
    tx_idle     = 19;
    rx_idle     = 81;
    req.valid   = 1'b0;
    req.angle_x = '0;
    req.angle_y = '0;
    req.angle_z = '0;
    res.ready   = 1'b0;
    cfg.valid   = 1'b0;
    cfg.index   = '0;
    cfg.data    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero angles, extremes, the quarter- and half-turn boundaries.
    send_angles(16'sd0, 16'sd0, 16'sd0);
    send_angles(16'sd32767, 16'sd32767, 16'sd32767);
    send_angles(-16'sd32768, -16'sd32768, -16'sd32768);
    send_angles(16'sd32767, -16'sd32768, 16'sd0);
    send_angles(16'sd1, -16'sd1, 16'sd0);
    send_angles(ANG_QUARTER, ANG_QUARTER, ANG_QUARTER);
    send_angles(ANG_QUARTER + 16'sd1, ANG_QUARTER - 16'sd1, -ANG_QUARTER);
    send_angles(ANG_HALF, -ANG_HALF, ANG_HALF + 16'sd1);
    send_angles(ANG_HALF - 16'sd1, -ANG_HALF - 16'sd1, 16'sd0);
    send_angles(16'sd0, ANG_QUARTER, ANG_HALF);
    send_angles(16'sd6434, -16'sd6434, 16'sd19302);
    send_angles(16'sd0, 16'sd0, 16'sd32767);
    send_angles(16'sd0, -16'sd32768, 16'sd0);
    send_angles(16'sh5555, 16'shaaaa, 16'sh5555);
    send_angles(16'shaaaa, 16'sh5555, 16'shaaaa);

    // Random phases, each under its own coefficient setting; pairs of phases share an idling mode.
    for (int p = 0; p < 6; p++) begin
      drain();
      load_coefs(setting[p]);
      case (p / 2)
        0: begin tx_idle = 19; rx_idle = 81; end
        1: begin tx_idle = 81; rx_idle = 19; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      for (int n = 0; n < 180; n++) begin
        send_angles(pick_angle(), pick_angle(), pick_angle());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a stalled handshake.
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
